// ===== rtl/hcb_pkg.sv =====
// shared constants, node record and helpers for the huffman code builder
package hcb_pkg;

    localparam int NUM_SYMBOLS = 32;
    localparam int FREQ_BITS   = 32;
    localparam int NODE_COUNT  = 2 * NUM_SYMBOLS - 1;
    localparam int SYM_W       = $clog2(NUM_SYMBOLS);
    localparam int IDX_W       = $clog2(NODE_COUNT);
    localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
    localparam int WEIGHT_W    = FREQ_BITS + SYM_W;

    // result field widths
    localparam int OSYM_W   = 5;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 5;
    localparam int BITS_W   = 42;
    localparam int CHARS_W  = 37;
    localparam int PROD_W   = FREQ_BITS + LEN_W;
    localparam int FIELDS_W = OSYM_W + CODE_W + LEN_W + 1 + BITS_W + CHARS_W + 1;
    localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8;
    localparam int IN_W     = 32;

    // one tree node as it travels along the chain
    typedef struct packed {
        logic                waiting;
        logic [WEIGHT_W-1:0] weight;
        logic [SYM_W-1:0]    tag;
        logic [IDX_W-1:0]    idx;
    } node_t;

    // controls from the sequencer to the chain
    typedef struct packed {
        logic shift;
        logic load_mode;
        logic first;
        logic commit;
        logic clear_all;
    } chain_ctrl_t;

    // ordering by (weight, tag)
    function automatic logic node_less(input node_t x, input node_t y);
        return (x.weight < y.weight) || ((x.weight == y.weight) && (x.tag < y.tag));
    endfunction

endpackage

// ===== rtl/hcb_cell.sv =====
// one storage cell of the node chain, takes its neighbor's node on shift
module hcb_cell
    import hcb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  logic  clear_all,
    input  node_t node_in,
    output node_t node_out
);

    logic                waiting_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SYM_W-1:0]    tag_reg;
    logic [IDX_W-1:0]    idx_reg;

    // waiting mark, cleared by reset and at the end of a table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
        end
        else if (clear_all)
        begin
            waiting_reg <= 1'b0;
        end
        else if (shift)
        begin
            waiting_reg <= node_in.waiting;
        end
    end

    // node payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            weight_reg <= node_in.weight;
            tag_reg    <= node_in.tag;
            idx_reg    <= node_in.idx;
        end
    end

    assign node_out = '{waiting: waiting_reg, weight: weight_reg, tag: tag_reg, idx: idx_reg};

endmodule

// ===== rtl/hcb_chain.sv =====
// ring of node cells with head-side update and two-smallest tracker
module hcb_chain
    import hcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctrl_t      ctrl,
    input  node_t            leaf_in,
    input  logic [IDX_W-1:0] clr_a,
    input  logic [IDX_W-1:0] clr_b,
    input  node_t            ins_node,
    output node_t            best1,
    output node_t            best2
);

    node_t            cell_q [NODE_COUNT];
    node_t            tail_in;
    node_t            head_clr;
    node_t            head_mod;
    node_t            base1;
    node_t            base2;
    node_t            best1_next;
    node_t            best2_next;
    node_t            best1_reg;
    node_t            best2_reg;
    node_t            ins_node_reg;
    logic             ins_valid_reg;
    logic             clr_valid_reg;
    logic [IDX_W-1:0] clr_a_reg;
    logic [IDX_W-1:0] clr_b_reg;
    logic             ins_take;

    // row of cells, each fed by its upper neighbor, the last fed by the tail
    for (genvar k = 0; k < NODE_COUNT; k++)
    begin : g_cell
        node_t nb;
        if (k == NODE_COUNT - 1)
        begin : g_tail
            assign nb = tail_in;
        end
        else
        begin : g_mid
            assign nb = cell_q[k + 1];
        end
        hcb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ctrl.shift),
            .clear_all(ctrl.clear_all),
            .node_in  (nb),
            .node_out (cell_q[k])
        );
    end

    // head update: retire the last two taken nodes, drop in the merged node
    always_comb
    begin
        head_clr = cell_q[0];
        if (clr_valid_reg && ((head_clr.idx == clr_a_reg) || (head_clr.idx == clr_b_reg)))
        begin
            head_clr.waiting = 1'b0;
        end
        head_mod = head_clr;
        ins_take = 1'b0;
        if (ins_valid_reg && !head_clr.waiting)
        begin
            head_mod = ins_node_reg;
            ins_take = 1'b1;
        end
    end

    assign tail_in = ctrl.load_mode ? leaf_in : head_mod;

    // pending updates for the next pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_valid_reg <= 1'b0;
            clr_valid_reg <= 1'b0;
        end
        else if (ctrl.clear_all)
        begin
            ins_valid_reg <= 1'b0;
            clr_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            ins_valid_reg <= 1'b1;
            clr_valid_reg <= 1'b1;
        end
        else if (ctrl.shift && !ctrl.load_mode && ins_take)
        begin
            ins_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            ins_node_reg <= ins_node;
            clr_a_reg    <= clr_a;
            clr_b_reg    <= clr_b;
        end
    end

    // two smallest waiting nodes seen at the head during a pass
    always_comb
    begin
        base1      = ctrl.first ? '0 : best1_reg;
        base2      = ctrl.first ? '0 : best2_reg;
        best1_next = base1;
        best2_next = base2;
        if (head_mod.waiting)
        begin
            if (!base1.waiting || node_less(head_mod, base1))
            begin
                best1_next = head_mod;
                best2_next = base1;
            end
            else if (!base2.waiting || node_less(head_mod, base2))
            begin
                best2_next = head_mod;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best1_reg <= '0;
            best2_reg <= '0;
        end
        else if (ctrl.shift && !ctrl.load_mode)
        begin
            best1_reg <= best1_next;
            best2_reg <= best2_next;
        end
    end

    assign best1 = best1_reg;
    assign best2 = best2_reg;

`ifndef SYNTHESIS
    a_best_order: assert property (@(posedge clk) disable iff (!rst_n)
        best2_reg.waiting |-> best1_reg.waiting && node_less(best1_reg, best2_reg))
        else $error("tracker order broken");
    a_ins_placed: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> !ctrl.shift)
        else $error("commit during shift");
    a_best_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        best2_reg.waiting |-> best1_reg.idx != best2_reg.idx)
        else $error("same node tracked twice");
`endif

endmodule

// ===== rtl/huffman_code_builder_core.sv =====
// top level: load, tree build on the node chain, code walk and result output
//
// Frequencies are taken one per cycle in symbol order until tlast. The tree
// is then built in the node chain: each merge is one full trip of the
// 63-cell ring past its head followed by a merge step, one merge for each
// present symbol but one. The code walk reads each merged node and writes
// its left and right child codes, the totals pass reads every loaded
// symbol, and each result is read, loaded and then held until the output
// takes it. No new frequency is taken until the last result has gone out.
module huffman_code_builder_core
    import hcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // frequency
    input  logic             s_tlast,   // last
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // symbol, code, code_length, present,
                                        // coded_bits, total_chars, overflow
    output logic             m_tlast    // last_result
);

    typedef enum logic [12:0] {
        S_LOAD   = 13'b0000000000001,
        S_SETUP  = 13'b0000000000010,
        S_ROT    = 13'b0000000000100,
        S_MERGE  = 13'b0000000001000,
        S_ROOT   = 13'b0000000010000,
        S_TRD    = 13'b0000000100000,
        S_TW1    = 13'b0000001000000,
        S_TW2    = 13'b0000010000000,
        S_SUM    = 13'b0000100000000,
        S_SUMEND = 13'b0001000000000,
        S_ORD    = 13'b0010000000000,
        S_OLD    = 13'b0100000000000,
        S_OWAIT  = 13'b1000000000000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          loaded_reg;
    logic [CNT_W-1:0]          present_reg;
    logic [CNT_W-1:0]          merges_reg;
    logic                      overflow_reg;
    logic [SYM_W-1:0]          last_sym_reg;
    logic [IDX_W-1:0]          next_reg;
    logic [IDX_W-1:0]          rot_reg;
    logic [IDX_W-1:0]          trav_reg;
    logic [SYM_W-1:0]          cnt_reg;
    logic [SYM_W-1:0]          rd_idx_reg;
    logic                      rd_pend_reg;
    logic [NUM_SYMBOLS-1:0]    done_reg;
    logic [BITS_W-1:0]         bits_reg;
    logic [CHARS_W-1:0]        chars_reg;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;
    logic                      out_last_reg;

    // memories
    logic [FREQ_BITS-1:0]      freq_mem [NUM_SYMBOLS];
    logic [LEN_W+CODE_W-1:0]   code_mem [NODE_COUNT];
    logic [2*IDX_W-1:0]        link_mem [NUM_SYMBOLS-1];
    logic [FREQ_BITS-1:0]      freq_rd_reg;
    logic [LEN_W+CODE_W-1:0]   code_rd_reg;
    logic [2*IDX_W-1:0]        link_rd_reg;

    logic                      in_accept;
    logic                      in_store;
    logic                      finish;
    logic [FREQ_BITS-1:0]      freq;
    logic [SYM_W-1:0]          cnt_last;
    chain_ctrl_t               ctrl;
    node_t                     leaf_in;
    node_t                     best1;
    node_t                     best2;
    node_t                     ins_node;
    logic [IDX_W-1:0]          left_idx;
    logic [IDX_W-1:0]          right_idx;
    logic [IDX_W-1:0]          child_l;
    logic [IDX_W-1:0]          child_r;
    logic [CODE_W-1:0]         par_code;
    logic [LEN_W-1:0]          par_len;
    logic                      cw_en;
    logic [IDX_W-1:0]          cw_addr;
    logic [LEN_W+CODE_W-1:0]   cw_data;
    logic                      cr_en;
    logic [IDX_W-1:0]          cr_addr;
    logic                      sel_done;
    logic [LEN_W-1:0]          sel_len;
    logic [CODE_W-1:0]         sel_code;
    logic [PROD_W-1:0]         prod;

    assign freq      = FREQ_BITS'(s_tdata);
    assign s_tready  = (state_reg == S_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign in_store  = in_accept && (loaded_reg < CNT_W'(NUM_SYMBOLS));
    assign finish    = (state_reg == S_OWAIT) && m_tready && out_last_reg;
    assign cnt_last  = SYM_W'(loaded_reg - 1'b1);

    // chain controls and the nodes handed to it
    always_comb
    begin
        ctrl.shift     = in_store || (state_reg == S_ROT);
        ctrl.load_mode = (state_reg == S_LOAD);
        ctrl.first     = (rot_reg == '0);
        ctrl.commit    = (state_reg == S_MERGE);
        ctrl.clear_all = finish;
        leaf_in.waiting = (freq != '0);
        leaf_in.weight  = WEIGHT_W'(freq);
        leaf_in.tag     = SYM_W'(loaded_reg);
        leaf_in.idx     = IDX_W'(loaded_reg);
        ins_node.waiting = 1'b1;
        ins_node.weight  = best1.weight + best2.weight;
        ins_node.tag     = (best1.tag > best2.tag) ? best1.tag : best2.tag;
        ins_node.idx     = next_reg;
    end

    hcb_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .leaf_in (leaf_in),
        .clr_a   (best1.idx),
        .clr_b   (best2.idx),
        .ins_node(ins_node),
        .best1   (best1),
        .best2   (best2)
    );

    // lighter node goes right, on a tie the first taken goes left
    assign left_idx  = (best1.weight < best2.weight) ? best2.idx : best1.idx;
    assign right_idx = (best1.weight < best2.weight) ? best1.idx : best2.idx;

    assign child_l  = link_rd_reg[2*IDX_W-1:IDX_W];
    assign child_r  = link_rd_reg[IDX_W-1:0];
    assign par_code = code_rd_reg[CODE_W-1:0];
    assign par_len  = code_rd_reg[LEN_W+CODE_W-1:CODE_W];

    // code memory write and read selection
    always_comb
    begin
        cw_en   = 1'b0;
        cw_addr = '0;
        cw_data = '0;
        if ((state_reg == S_SETUP) && (present_reg == CNT_W'(1)))
        begin
            cw_en   = 1'b1;
            cw_addr = IDX_W'(last_sym_reg);
            cw_data = {LEN_W'(1), CODE_W'(0)};
        end
        else if (state_reg == S_ROOT)
        begin
            cw_en   = 1'b1;
            cw_addr = next_reg - 1'b1;
        end
        else if (state_reg == S_TW1)
        begin
            cw_en   = 1'b1;
            cw_addr = child_l;
            cw_data = {par_len + 1'b1, par_code << 1};
        end
        else if (state_reg == S_TW2)
        begin
            cw_en   = 1'b1;
            cw_addr = child_r;
            cw_data = {par_len + 1'b1, (par_code << 1) | CODE_W'(1)};
        end
        cr_en   = (state_reg == S_TRD) || (state_reg == S_SUM) || (state_reg == S_ORD);
        cr_addr = (state_reg == S_TRD) ? trav_reg : IDX_W'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            code_mem[cw_addr] <= cw_data;
        end
        if (cr_en)
        begin
            code_rd_reg <= code_mem[cr_addr];
        end
    end

    // frequency memory
    always_ff @(posedge clk)
    begin
        if (in_store)
        begin
            freq_mem[SYM_W'(loaded_reg)] <= freq;
        end
        if ((state_reg == S_SUM) || (state_reg == S_ORD))
        begin
            freq_rd_reg <= freq_mem[cnt_reg];
        end
    end

    // child links of merged nodes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MERGE)
        begin
            link_mem[SYM_W'(next_reg - IDX_W'(NUM_SYMBOLS))] <= {left_idx, right_idx};
        end
        if (state_reg == S_TRD)
        begin
            link_rd_reg <= link_mem[SYM_W'(trav_reg - IDX_W'(NUM_SYMBOLS))];
        end
    end

    // leaf values as read back
    assign sel_done = done_reg[rd_idx_reg];
    assign sel_len  = sel_done ? code_rd_reg[LEN_W+CODE_W-1:CODE_W] : '0;
    assign sel_code = sel_done ? code_rd_reg[CODE_W-1:0] : '1;
    assign prod     = PROD_W'(freq_rd_reg) * PROD_W'(sel_len);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (present_reg > CNT_W'(1))
                begin
                    state_next = S_ROT;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_ROT:
            begin
                if (rot_reg == IDX_W'(NODE_COUNT - 1))
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                state_next = (merges_reg == CNT_W'(1)) ? S_ROOT : S_ROT;
            end
            S_ROOT:   state_next = S_TRD;
            S_TRD:    state_next = S_TW1;
            S_TW1:    state_next = S_TW2;
            S_TW2:
            begin
                state_next = (trav_reg == IDX_W'(NUM_SYMBOLS)) ? S_SUM : S_TRD;
            end
            S_SUM:
            begin
                if (cnt_reg == cnt_last)
                begin
                    state_next = S_SUMEND;
                end
            end
            S_SUMEND: state_next = S_ORD;
            S_ORD:    state_next = S_OLD;
            S_OLD:    state_next = S_OWAIT;
            S_OWAIT:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? S_LOAD : S_ORD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            present_reg   <= '0;
            merges_reg    <= '0;
            overflow_reg  <= 1'b0;
            last_sym_reg  <= '0;
            next_reg      <= '0;
            rot_reg       <= '0;
            trav_reg      <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            done_reg      <= '0;
            bits_reg      <= '0;
            chars_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_SUM);

            // load of one frequency
            if (in_accept)
            begin
                if (in_store)
                begin
                    loaded_reg <= loaded_reg + 1'b1;
                    if (freq != '0)
                    begin
                        present_reg  <= present_reg + 1'b1;
                        last_sym_reg <= SYM_W'(loaded_reg);
                    end
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            // start of build
            if (state_reg == S_SETUP)
            begin
                bits_reg   <= '0;
                chars_reg  <= '0;
                merges_reg <= present_reg - 1'b1;
                next_reg   <= IDX_W'(NUM_SYMBOLS);
                rot_reg    <= '0;
                cnt_reg    <= '0;
                if (present_reg == CNT_W'(1))
                begin
                    done_reg <= NUM_SYMBOLS'(1) << last_sym_reg;
                end
                else
                begin
                    done_reg <= '0;
                end
            end

            // ring passes and merges
            if (state_reg == S_ROT)
            begin
                rot_reg <= (rot_reg == IDX_W'(NODE_COUNT - 1)) ? '0 : rot_reg + 1'b1;
            end
            if (state_reg == S_MERGE)
            begin
                merges_reg <= merges_reg - 1'b1;
                next_reg   <= next_reg + 1'b1;
            end

            // walk from the root down
            if (state_reg == S_ROOT)
            begin
                trav_reg <= next_reg - 1'b1;
            end
            if ((state_reg == S_TW1) && (child_l < IDX_W'(NUM_SYMBOLS)))
            begin
                done_reg[SYM_W'(child_l)] <= 1'b1;
            end
            if (state_reg == S_TW2)
            begin
                if (child_r < IDX_W'(NUM_SYMBOLS))
                begin
                    done_reg[SYM_W'(child_r)] <= 1'b1;
                end
                trav_reg <= trav_reg - 1'b1;
            end

            // totals pass
            if (state_reg == S_SUM)
            begin
                rd_idx_reg <= cnt_reg;
                cnt_reg    <= (cnt_reg == cnt_last) ? '0 : cnt_reg + 1'b1;
            end
            if (rd_pend_reg)
            begin
                chars_reg <= chars_reg + CHARS_W'(freq_rd_reg);
                bits_reg  <= bits_reg + BITS_W'(prod);
            end

            // results
            if (state_reg == S_ORD)
            begin
                rd_idx_reg <= cnt_reg;
            end
            if (state_reg == S_OLD)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (rd_idx_reg == cnt_last);
            end
            if ((state_reg == S_OWAIT) && m_tready)
            begin
                out_valid_reg <= 1'b0;
                cnt_reg       <= out_last_reg ? '0 : cnt_reg + 1'b1;
            end
            if (finish)
            begin
                loaded_reg   <= '0;
                present_reg  <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OLD)
        begin
            out_data_reg <= OUT_W'({overflow_reg, chars_reg, bits_reg,
                                    (freq_rd_reg != '0), sel_len, sel_code,
                                    OSYM_W'(rd_idx_reg)});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");
    a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> best1.waiting && best2.waiting)
        else $error("merge without two nodes");
    a_merge_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> next_reg < IDX_W'(NODE_COUNT))
        else $error("node index out of range");
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CNT_W'(cnt_reg) < loaded_reg))
        else $error("result index beyond loaded symbols");
`endif

endmodule

// ===== tb/huffman_code_builder_core_test.sv =====
// testbench for the huffman code builder: frequency tables in, checked codes out
module huffman_code_builder_core_test;
    import hcb_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        logic [4:0]  symbol;
        logic [31:0] code;
        logic [4:0]  code_length;
        logic        present;
        logic [41:0] coded_bits;
        logic [36:0] total_chars;
        logic        overflow;
        logic        last_result;
    } code_entry_t;

    // one frequency request
    typedef struct packed {
        logic [31:0] freq;
        logic        last;
    } freq_req_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    huffman_code_builder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    freq_req_t   pending_reqs[$];
    code_entry_t expected_codes[$];
    int          error_count;
    bit          quiet_tail;
    bit          drain_hold;
    int          hold_cycles;

    // predictor state
    logic [36:0] nd_weight[NODE_COUNT];
    logic [4:0]  nd_tag[NODE_COUNT];
    int          nd_left[NODE_COUNT];
    int          nd_right[NODE_COUNT];
    bit          nd_waiting[NODE_COUNT];
    logic [63:0] nd_code[NODE_COUNT];
    int          nd_len[NODE_COUNT];
    logic [31:0] sym_code[NUM_SYMBOLS];
    int          sym_len[NUM_SYMBOLS];
    int          sym_count;
    bit          table_overflow;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // smallest waiting node by (weight, tag)
    function automatic int pick_lightest(input int limit);
        int best;
        bit found;
        best = 0;
        found = 0;
        for (int i = 0; i < limit; i++)
        begin
            if (nd_waiting[i] && (!found || nd_weight[i] < nd_weight[best] ||
                (nd_weight[i] == nd_weight[best] && nd_tag[i] < nd_tag[best])))
            begin
                best = i;
                found = 1;
            end
        end
        nd_waiting[best] = 0;
        return best;
    endfunction

    // builds the code table for the loaded symbols
    task automatic build_code_table();
        int present;
        int next;
        int a;
        int b;
        int l;
        int r;
        present = 0;
        next = NUM_SYMBOLS;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            sym_code[i] = '1;
            sym_len[i] = 0;
        end
        for (int i = 0; i < sym_count; i++)
            if (nd_waiting[i])
                present++;
        if (present == 1)
        begin
            for (int i = 0; i < sym_count; i++)
                if (nd_waiting[i])
                begin
                    sym_code[i] = 0;
                    sym_len[i] = 1;
                    nd_waiting[i] = 0;
                end
        end
        else if (present > 1)
        begin
            for (int i = 0; i + 1 < present; i++)
            begin
                a = pick_lightest(next);
                b = pick_lightest(next);
                nd_weight[next] = nd_weight[a] + nd_weight[b];
                nd_tag[next] = (nd_tag[a] > nd_tag[b]) ? nd_tag[a] : nd_tag[b];
                if (nd_weight[a] < nd_weight[b])
                begin
                    nd_left[next] = b;
                    nd_right[next] = a;
                end
                else
                begin
                    nd_left[next] = a;
                    nd_right[next] = b;
                end
                nd_waiting[next] = 1;
                next++;
            end
            nd_waiting[next-1] = 0;
            nd_code[next-1] = 0;
            nd_len[next-1] = 0;
            // walk down from the root
            for (int i = next - 1; i >= NUM_SYMBOLS; i--)
            begin
                l = nd_left[i];
                r = nd_right[i];
                nd_code[l] = nd_code[i] << 1;
                nd_code[r] = (nd_code[i] << 1) | 64'd1;
                nd_len[l] = nd_len[i] + 1;
                nd_len[r] = nd_len[i] + 1;
                if (l < NUM_SYMBOLS)
                begin
                    sym_code[l] = nd_code[l][31:0];
                    sym_len[l] = nd_len[l];
                end
                if (r < NUM_SYMBOLS)
                begin
                    sym_code[r] = nd_code[r][31:0];
                    sym_len[r] = nd_len[r];
                end
            end
        end
    endtask

    // takes one accepted frequency and queues the codes it causes
    task automatic accept_frequency(input freq_req_t req);
        logic [63:0] bits_sum;
        logic [63:0] chars_sum;
        code_entry_t e;
        bits_sum = 0;
        chars_sum = 0;
        if (sym_count < NUM_SYMBOLS)
        begin
            nd_weight[sym_count] = {5'd0, req.freq};
            nd_tag[sym_count] = sym_count[4:0];
            nd_waiting[sym_count] = (req.freq != 0);
            sym_count++;
        end
        else
            table_overflow = 1;
        if (req.last)
        begin
            build_code_table();
            for (int i = 0; i < sym_count; i++)
            begin
                chars_sum += nd_weight[i];
                bits_sum += 64'(sym_len[i]) * nd_weight[i];
            end
            for (int i = 0; i < sym_count; i++)
            begin
                e.symbol = i[4:0];
                e.code = sym_code[i];
                e.code_length = sym_len[i][4:0];
                e.present = (nd_weight[i] != 0);
                e.coded_bits = bits_sum[41:0];
                e.total_chars = chars_sum[36:0];
                e.overflow = table_overflow;
                e.last_result = (i + 1 == sym_count);
                expected_codes.push_back(e);
            end
            sym_count = 0;
            table_overflow = 0;
            for (int i = 0; i < NODE_COUNT; i++)
                nd_waiting[i] = 0;
        end
    endtask

    // random frequency with a mix of zero, tiny, equal and huge values
    function automatic logic [31:0] random_freq();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return $urandom_range(1, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: return $urandom;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    task automatic push_table(input logic [31:0] freqs[$]);
        freq_req_t r;
        foreach (freqs[i])
        begin
            r.freq = freqs[i];
            r.last = (i == freqs.size() - 1);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic push_random_table(input int n);
        logic [31:0] f[$];
        for (int i = 0; i < n; i++)
            f.push_back(random_freq());
        push_table(f);
    endtask

    // handshake seen at the last rising edge
    bit s_tready_seen;

    // driver: offers pending frequencies with random bursts of idle
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (send_gap > 0 && !(s_tvalid && !s_tready_seen))
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (s_tvalid && !s_tready_seen)
            begin
                // hold the offered request
            end
            else if (pending_reqs.size() > 0 && !drain_hold)
            begin
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_reqs[0].freq;
                    s_tlast <= pending_reqs[0].last;
                    void'(pending_reqs.pop_front());
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        s_tready_seen = s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            accept_frequency('{freq: s_tdata, last: s_tlast});
    end

    // receiver ready with random stalls and one long hold-off
    int recv_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            recv_gap <= $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: compares each code with the oldest expected one
    code_entry_t got;
    code_entry_t want;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.symbol = m_tdata[4:0];
            got.code = m_tdata[36:5];
            got.code_length = m_tdata[41:37];
            got.present = m_tdata[42];
            got.coded_bits = m_tdata[84:43];
            got.total_chars = m_tdata[121:85];
            got.overflow = m_tdata[122];
            got.last_result = m_tlast;
            if (expected_codes.size() == 0)
                report_mismatch("unexpected code", got.symbol, 0);
            else
            begin
                want = expected_codes.pop_front();
                if (got.symbol != want.symbol)
                    report_mismatch("symbol", got.symbol, want.symbol);
                if (got.code != want.code)
                    report_mismatch("code", got.code, want.code);
                if (got.code_length != want.code_length)
                    report_mismatch("code_length", got.code_length, want.code_length);
                if (got.present != want.present)
                    report_mismatch("present", got.present, want.present);
                if (got.coded_bits != want.coded_bits)
                    report_mismatch("coded_bits", got.coded_bits, want.coded_bits);
                if (got.total_chars != want.total_chars)
                    report_mismatch("total_chars", got.total_chars, want.total_chars);
                if (got.overflow != want.overflow)
                    report_mismatch("overflow", got.overflow, want.overflow);
                if (got.last_result != want.last_result)
                    report_mismatch("last_result", got.last_result, want.last_result);
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] f[$];
        int sent;
        error_count = 0;
        quiet_tail = 0;
        drain_hold = 0;
        hold_cycles = 0;
        sym_count = 0;
        table_overflow = 0;
        for (int i = 0; i < NODE_COUNT; i++)
            nd_waiting[i] = 0;
        // directed: lone symbol, no symbols, equal weights, extremes, skewed tree
        f = '{32'd0, 32'd5, 32'd0};
        push_table(f);
        f = '{32'd0, 32'd0};
        push_table(f);
        f = '{32'd7};
        push_table(f);
        f = '{32'd3, 32'd3, 32'd3, 32'd3};
        push_table(f);
        f = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hAAAA_5555};
        push_table(f);
        f = '{};
        for (int i = 0; i < 32; i++)
            f.push_back(32'd1 << i);
        push_table(f);
        // over capacity: the extra requests are dropped and flagged
        f = '{};
        for (int i = 0; i < 35; i++)
            f.push_back(random_freq());
        push_table(f);
        sent = 0;
        // random tables, mostly small
        while (sent < 180)
        begin
            automatic int n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 8);
            push_random_table(n);
            sent += n;
        end
        @(posedge rst_n);
        // long receiver hold-off while tables keep coming
        repeat (20) @(posedge clk);
        hold_cycles = 3000;
        // sender pauses until everything has drained once
        wait (pending_reqs.size() < 150);
        drain_hold = 1;
        wait (expected_codes.size() == 0 && !s_tvalid);
        repeat (2500) @(posedge clk);
        drain_hold = 0;
        wait (pending_reqs.size() < 40);
        quiet_tail = 1;
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_codes.size() == 0);
        repeat (2500) @(posedge clk);
        if (error_count == 0)
            $display("PASS huffman_code_builder_core");
        else
            $display("FAIL huffman_code_builder_core");
        $finish;
    end

    // timeout
    initial
    begin
        #(20 * 2000000);
        $display("FAIL huffman_code_builder_core");
        $finish;
    end
endmodule
